/* rtl/ile_pkg.sv */
// ile_pkg: shared constants, request codes and result flag type of the indexed list engine.
// No dependencies; imported by ile_ctrl and indexed_list_engine_top.
`timescale 1ns / 1ps

package ile_pkg;

  // Default sizing of the element store
  localparam int ILE_CAPACITY  = 256;
  localparam int ILE_DATA_BITS = 32;

  // Request codes carried in the input tuser
  localparam logic [2:0] FN_ADD_HEAD  = 3'd0;
  localparam logic [2:0] FN_ADD_TAIL  = 3'd1;
  localparam logic [2:0] FN_TAKE_HEAD = 3'd2;
  localparam logic [2:0] FN_TAKE_TAIL = 3'd3;
  localparam logic [2:0] FN_READ_AT   = 3'd4;
  localparam logic [2:0] FN_INSERT_AT = 3'd5;
  localparam logic [2:0] FN_REMOVE_AT = 3'd6;

  // Status flags of one result item
  typedef struct packed {
    logic full;
    logic done;
  } res_flag_t;

endpackage

/* rtl/ile_store.sv */
// ile_store: single-port-write, single-port-read element memory with registered read data.
// Standalone; used by indexed_list_engine_top.
`timescale 1ns / 1ps

module ile_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ile_ctrl.sv */
// ile_ctrl: request decoder and shift sequencer; moves elements one per cycle through the store.
// Depends on ile_pkg; drives the ports of ile_store.
`timescale 1ns / 1ps

module ile_ctrl
  import ile_pkg::*;
#(
  parameter int CAPACITY  = ILE_CAPACITY,
  parameter int DATA_BITS = ILE_DATA_BITS,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request side
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  input  logic [CW-1:0]        in_pos,
  input  logic [DATA_BITS-1:0] in_val,
  // store side
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output logic [DATA_BITS-1:0] mem_wr_data,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  logic [DATA_BITS-1:0] mem_rd_data,
  // result side
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [DATA_BITS-1:0] res_data,
  output res_flag_t            res_flags,
  output logic [CW-1:0]        res_len
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_TAIL = 5'b00100,
    ST_PUT  = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);
  localparam logic [AW-1:0] ONE_ADR = AW'(1);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]        end_r, end_nxt;
  logic [AW-1:0]        start_r, start_nxt;
  logic                 open_r, open_nxt;
  logic                 want_r, want_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic [DATA_BITS-1:0] val_r, val_nxt;
  logic [DATA_BITS-1:0] res_data_r, res_data_nxt;
  logic                 res_done_r, res_done_nxt;
  logic                 res_full_r, res_full_nxt;
  logic [CW-1:0]        res_len_r, res_len_nxt;

  logic                 accept;
  logic [CW-1:0]        ins_at;
  logic [AW-1:0]        last_adr;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_adr = AW'(cnt_r - ONE_CNT);

  // Pick the slot a push or insert lands in
  always_comb begin
    unique case (in_func)
      FN_ADD_HEAD: ins_at = '0;
      FN_ADD_TAIL: ins_at = cnt_r;
      default:     ins_at = in_pos;
    endcase
  end

  // Decode, scan, write back and hand over the result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    start_nxt     = start_r;
    open_nxt      = open_r;
    want_nxt      = want_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    val_nxt       = val_r;
    res_data_nxt  = res_data_r;
    res_done_nxt  = res_done_r;
    res_full_nxt  = res_full_r;
    res_len_nxt   = res_len_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = start_r;
    mem_wr_data   = val_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ptr_r;
    res_valid     = 1'b0;

    // Retire the read issued last cycle: move it one place, capture it or drop it
    if (pend_r && (state_r == ST_SCAN || state_r == ST_TAIL)) begin
      if (open_r) begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pend_addr_r + ONE_ADR;
        mem_wr_data = mem_rd_data;
      end else if (pend_addr_r == start_r) begin
        if (want_r) begin
          res_data_nxt = mem_rd_data;
        end
      end else begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pend_addr_r - ONE_ADR;
        mem_wr_data = mem_rd_data;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt      = in_val;
          res_data_nxt = '0;
          res_done_nxt = 1'b0;
          res_full_nxt = 1'b0;
          res_len_nxt  = cnt_r;
          state_nxt    = ST_RESP;
          unique case (in_func)
            FN_ADD_HEAD, FN_ADD_TAIL, FN_INSERT_AT: begin
              if (ins_at > cnt_r) begin
                res_done_nxt = 1'b0;
              end else if (cnt_r == CAP_CNT) begin
                res_full_nxt = 1'b1;
              end else begin
                cnt_nxt      = cnt_r + ONE_CNT;
                res_len_nxt  = cnt_r + ONE_CNT;
                res_done_nxt = 1'b1;
                start_nxt    = AW'(ins_at);
                open_nxt     = 1'b1;
                want_nxt     = 1'b0;
                if (ins_at == cnt_r) begin
                  state_nxt = ST_PUT;
                end else begin
                  ptr_nxt   = last_adr;
                  end_nxt   = AW'(ins_at);
                  state_nxt = ST_SCAN;
                end
              end
            end
            FN_TAKE_HEAD, FN_TAKE_TAIL: begin
              if (cnt_r != '0) begin
                cnt_nxt      = cnt_r - ONE_CNT;
                res_len_nxt  = cnt_r - ONE_CNT;
                res_done_nxt = 1'b1;
                open_nxt     = 1'b0;
                want_nxt     = 1'b1;
                start_nxt    = (in_func == FN_TAKE_HEAD) ? '0 : last_adr;
                ptr_nxt      = (in_func == FN_TAKE_HEAD) ? '0 : last_adr;
                end_nxt      = last_adr;
                state_nxt    = ST_SCAN;
              end
            end
            FN_READ_AT, FN_REMOVE_AT: begin
              if (in_pos < cnt_r) begin
                res_done_nxt = 1'b1;
                open_nxt     = 1'b0;
                start_nxt    = AW'(in_pos);
                ptr_nxt      = AW'(in_pos);
                state_nxt    = ST_SCAN;
                if (in_func == FN_READ_AT) begin
                  want_nxt = 1'b1;
                  end_nxt  = AW'(in_pos);
                end else begin
                  want_nxt    = 1'b0;
                  end_nxt     = last_adr;
                  cnt_nxt     = cnt_r - ONE_CNT;
                  res_len_nxt = cnt_r - ONE_CNT;
                end
              end
            end
            default: begin
              res_done_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_rd_en     = 1'b1;
        mem_rd_addr   = ptr_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = ptr_r;
        if (ptr_r == end_r) begin
          state_nxt = ST_TAIL;
        end else begin
          ptr_nxt = open_r ? (ptr_r - ONE_ADR) : (ptr_r + ONE_ADR);
        end
      end
      ST_TAIL: begin
        state_nxt = open_r ? ST_PUT : ST_RESP;
      end
      ST_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = start_r;
        mem_wr_data = val_r;
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    end_r       <= end_nxt;
    start_r     <= start_nxt;
    open_r      <= open_nxt;
    want_r      <= want_nxt;
    pend_addr_r <= pend_addr_nxt;
    val_r       <= val_nxt;
    res_data_r  <= res_data_nxt;
    res_done_r  <= res_done_nxt;
    res_full_r  <= res_full_nxt;
    res_len_r   <= res_len_nxt;
  end

  assign res_data       = res_data_r;
  assign res_flags.done = res_done_r;
  assign res_flags.full = res_full_r;
  assign res_len        = res_len_r;

  // The last read of a scan is always retired in the tail cycle
  a_tail_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAIL) |-> pend_r)
    else $error("tail cycle without a pending read");

  // A shift never reads the entry it writes in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("store read and write hit the same entry");

  // Element count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("element count beyond capacity");

  // Count moves only when an item is taken
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept) |=> $stable(cnt_r))
    else $error("element count changed without an item");

  // Full refusal and success never come together
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res_flags.done && res_flags.full))
    else $error("result both done and refused");

endmodule

/* rtl/indexed_list_engine_top.sv */
// Ordered sequence of up to CAPACITY signed elements with front, back and indexed operations.
// A failed, ignored or refused request or an unused code goes straight to the result. A push
// to the back writes the element and then hands over the result. A read, a pop or a remove
// scans the elements it reads (one for a read or a pop from the back, every element for a pop
// from the front, position to end for a remove); a push to the front or an insert moves each
// element from the end down to its position up one place, then writes the new element. The
// element memory reads and writes one element per cycle.
// A read outside the sequence returns 0, a pop from an empty sequence reports failure, an
// insert past the end or a remove outside the sequence is ignored, and a push or insert
// into a full store is refused with full_refused set. The result is held in an output
// register, so the next item is taken while a finished result still waits.
// Depends on ile_pkg, ile_store and ile_ctrl.
`timescale 1ns / 1ps

module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int CAPACITY  = ILE_CAPACITY,
  parameter int DATA_BITS = ILE_DATA_BITS,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY),
  localparam int TD_W = ((CW + DATA_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  // request channel
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [TD_W-1:0] in_tdata,   // position, data_in, zero fill
  input  logic [2:0]      in_tuser,   // func
  // result channel
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [TD_W-1:0] out_tdata,  // data_out, length, zero fill
  output logic [1:0]      out_tuser   // done_res, full_refused
);

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [DATA_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [DATA_BITS-1:0] mem_rd_data;

  logic                 res_valid;
  logic                 res_ready;
  logic [DATA_BITS-1:0] res_data;
  res_flag_t            res_flags;
  logic [CW-1:0]        res_len;

  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_BITS-1:0] out_data_r;
  res_flag_t            out_flags_r;
  logic [CW-1:0]        out_len_r;

  ile_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ile_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (in_tuser),
    .in_pos      (in_tdata[CW-1:0]),
    .in_val      (in_tdata[CW +: DATA_BITS]),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .res_flags   (res_flags),
    .res_len     (res_len)
  );

  // Take a result whenever the output register is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result item until it is taken
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r  <= res_data;
      out_flags_r <= res_flags;
      out_len_r   <= res_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'({out_len_r, out_data_r});
  assign out_tuser  = {out_flags_r.full, out_flags_r.done};

endmodule
